[sv/iefa_pkg.sv]
// ----------------------------------------------------------------------------
// iefa_pkg: shared types and constants of the inverse error function block
// Fixed-point formats, pipeline depths and the Q.56 coefficient set.
// ----------------------------------------------------------------------------
package iefa_pkg;

   localparam int IN_W         = 32;
   localparam int FB           = IN_W - 1;
   localparam int OUT_W        = 32;
   localparam int OUT_FB       = 27;
   localparam int QB           = 56;
   localparam int LOG_STEPS    = QB;
   localparam int SQRT_STEPS   = 59;
   localparam int HORNER_STEPS = 8;
   localparam int POLY_BASE    = HORNER_STEPS + 1;
   localparam int FINAL_SHIFT  = QB + FB - OUT_FB;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic          neg;
      logic [FB-1:0] mag;
   } arg_type;

   // N * 10^-E as Q.56, rounded to nearest; restoring long division
   function automatic logic [63:0] dec_to_q(input logic [63:0] n, input int e);
      logic [63:0]  d;
      logic [63:0]  rem;
      logic [127:0] q;
      d   = 64'd1;
      rem = '0;
      q   = '0;
      for (int i = 0; i < e; i++) d = d * 64'd10;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n[i]};
         q   = {q[126:0], 1'b0};
         if (rem >= d) begin
            rem  = rem - d;
            q[0] = 1'b1;
         end
      end
      for (int i = 0; i < QB + 1; i++) begin
         rem = {rem[62:0], 1'b0};
         q   = {q[126:0], 1'b0};
         if (rem >= d) begin
            rem  = rem - d;
            q[0] = 1'b1;
         end
      end
      q = q + 128'd1;
      return q[64:1];
   endfunction

   // first polynomial highest order first, then the second one
   function automatic logic [63:0] coef_q(input int idx);
      logic [63:0] mant;
      int          dexp;
      logic        neg;
      logic [63:0] v;
      mant = '0;
      dexp = 0;
      neg  = 1'b0;
      case (idx)
         0: begin mant = 64'd281022636; dexp = 16; neg = 1'b0; end
         1: begin mant = 64'd343273939; dexp = 15; neg = 1'b0; end
         2: begin mant = 64'd35233877;  dexp = 13; neg = 1'b1; end
         3: begin mant = 64'd439150654; dexp = 14; neg = 1'b1; end
         4: begin mant = 64'd21858087;  dexp = 11; neg = 1'b0; end
         5: begin mant = 64'd125372503; dexp = 11; neg = 1'b1; end
         6: begin mant = 64'd417768164; dexp = 11; neg = 1'b1; end
         7: begin mant = 64'd246640727; dexp = 9;  neg = 1'b0; end
         8: begin mant = 64'd150140941; dexp = 8;  neg = 1'b0; end
         9: begin mant = 64'd200214257; dexp = 12; neg = 1'b1; end
         10: begin mant = 64'd100950558; dexp = 12; neg = 1'b0; end
         11: begin mant = 64'd134934322; dexp = 11; neg = 1'b0; end
         12: begin mant = 64'd367342844; dexp = 11; neg = 1'b1; end
         13: begin mant = 64'd573950773; dexp = 11; neg = 1'b0; end
         14: begin mant = 64'd76224613;  dexp = 10; neg = 1'b1; end
         15: begin mant = 64'd943887047; dexp = 11; neg = 1'b0; end
         16: begin mant = 64'd100167406; dexp = 8;  neg = 1'b0; end
         17: begin mant = 64'd283297682; dexp = 8;  neg = 1'b0; end
         default: begin mant = '0; dexp = 0; neg = 1'b0; end
      endcase
      v = dec_to_q(mant, dexp);
      return neg ? (64'd0 - v) : v;
   endfunction

   localparam logic [63:0] LN2_Q = dec_to_q(64'd693147180559945309, 18);

   localparam logic [63:0] COEF_TAB [18] = '{
      coef_q(0),  coef_q(1),  coef_q(2),  coef_q(3),  coef_q(4),  coef_q(5),
      coef_q(6),  coef_q(7),  coef_q(8),  coef_q(9),  coef_q(10), coef_q(11),
      coef_q(12), coef_q(13), coef_q(14), coef_q(15), coef_q(16), coef_q(17)
   };

   localparam logic [63:0] LOG_BIAS    = 64'(2 * FB) << QB;
   localparam logic [63:0] W_SPLIT     = 64'd5 << QB;
   localparam logic [63:0] W_CENTER    = 64'd5 << (QB - 1);
   localparam logic [63:0] SQRT_CENTER = 64'd3 << QB;

endpackage

[sv/iefa_mul.sv]
// ----------------------------------------------------------------------------
// iefa_mul: two-stage unsigned 64 x 64 multiplier
// Stage one registers four 32 x 32 partial products, stage two sums them.
// ----------------------------------------------------------------------------
module iefa_mul (
   input  logic         clock,
   input  logic         adv,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic [127:0] prod
);

   logic [63:0]  pp_ll_ff, pp_lh_ff, pp_hl_ff, pp_hh_ff;
   logic [63:0]  pp_ll_in, pp_lh_in, pp_hl_in, pp_hh_in;
   logic [127:0] prod_ff, prod_in;

   assign pp_ll_in = 64'(op_a[31:0])  * 64'(op_b[31:0]);
   assign pp_lh_in = 64'(op_a[31:0])  * 64'(op_b[63:32]);
   assign pp_hl_in = 64'(op_a[63:32]) * 64'(op_b[31:0]);
   assign pp_hh_in = 64'(op_a[63:32]) * 64'(op_b[63:32]);

   assign prod_in = {pp_hh_ff, pp_ll_ff}
                  + {32'd0, pp_lh_ff, 32'd0}
                  + {32'd0, pp_hl_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
         pp_hh_ff <= pp_hh_in;
         prod_ff  <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

[sv/iefa_front.sv]
// ----------------------------------------------------------------------------
// iefa_front: input side of the inverse error function block
// Takes arguments, splits them into sign and clamped magnitude, queues them.
// ----------------------------------------------------------------------------
module iefa_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [iefa_pkg::IN_W-1:0] req_x_value,
   input  logic                      pop,
   output logic                      head_valid,
   output iefa_pkg::arg_type         head_arg
);

   iefa_pkg::arg_type                queue_mem [iefa_pkg::QUEUE_DEPTH];
   logic [iefa_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [iefa_pkg::QPTR_W:0]        count_ff, count_in;
   logic [iefa_pkg::IN_W-1:0]        abs_val;
   iefa_pkg::arg_type                arg_in;
   logic                             push;

   // fold the sign away; minus one maps onto the largest magnitude
   always_comb begin
      arg_in.neg = req_x_value[iefa_pkg::FB];
      abs_val    = arg_in.neg ? (~req_x_value + 1'b1) : req_x_value;
      arg_in.mag = abs_val[iefa_pkg::FB] ? '1 : abs_val[iefa_pkg::FB-1:0];
   end

   assign req_ready  = (count_ff != (iefa_pkg::QPTR_W + 1)'(iefa_pkg::QUEUE_DEPTH));
   assign push       = req_valid & req_ready;
   assign head_valid = (count_ff != '0);
   assign head_arg   = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (iefa_pkg::QPTR_W + 1)'(push)
                           - (iefa_pkg::QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= arg_in;
      end
   end

endmodule

[sv/iefa_log.sv]
// ----------------------------------------------------------------------------
// iefa_log: log sum pipeline
// Forms -log2(1-|x|) - log2(1+|x|) in Q.56, one squaring per fraction bit.
// ----------------------------------------------------------------------------
module iefa_log (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  iefa_pkg::arg_type in_arg,
   output logic              out_valid,
   output iefa_pkg::arg_type out_arg,
   output logic [63:0]       out_lsum
);

   typedef struct packed {
      iefa_pkg::arg_type         arg;
      logic [4:0]                e1;
      logic [iefa_pkg::QB-1:0]   f1;
      logic [iefa_pkg::QB-1:0]   f2;
   } side_type;

   logic              a_vld_ff, b_vld_ff, c_vld_ff;
   iefa_pkg::arg_type a_arg_ff, b_arg_ff, c_arg_ff;
   logic [31:0]       n1_in, b_n1_ff;
   logic [4:0]        e1_in, b_e1_ff;
   logic [63:0]       lsum_in, c_lsum_ff;

   logic [62:0]       m1 [iefa_pkg::LOG_STEPS+1];
   logic [62:0]       m2 [iefa_pkg::LOG_STEPS+1];
   side_type          side [iefa_pkg::LOG_STEPS+1];
   logic              vld [iefa_pkg::LOG_STEPS+1];

   // leading one of 1 - |x|
   always_comb begin
      n1_in = 32'h8000_0000 - {1'b0, a_arg_ff.mag};
      e1_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (n1_in[i]) e1_in = 5'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= vld[iefa_pkg::LOG_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_arg_ff  <= in_arg;
         b_arg_ff  <= a_arg_ff;
         b_n1_ff   <= n1_in;
         b_e1_ff   <= e1_in;
         c_arg_ff  <= side[iefa_pkg::LOG_STEPS].arg;
         c_lsum_ff <= lsum_in[63] ? '0 : lsum_in;
      end
   end

   // normalize both factors to Q1.62; 1 + |x| always has its top bit at F
   assign m1[0]   = {31'd0, b_n1_ff} << (6'd62 - {1'b0, b_e1_ff});
   assign m2[0]   = {1'b1, b_arg_ff.mag, 31'd0};
   assign side[0] = '{arg: b_arg_ff, e1: b_e1_ff, f1: '0, f2: '0};
   assign vld[0]  = b_vld_ff;

   for (genvar k = 0; k < iefa_pkg::LOG_STEPS; k++) begin : g_step
      logic [127:0] sq1, sq2;
      logic [63:0]  hi1, hi2;
      logic         s1_vld_ff, s2_vld_ff;
      side_type     s1_side_ff, s2_side_ff;

      iefa_mul u_sq1 (.clock(clock), .adv(adv), .op_a({1'b0, m1[k]}),
                      .op_b({1'b0, m1[k]}), .prod(sq1));
      iefa_mul u_sq2 (.clock(clock), .adv(adv), .op_a({1'b0, m2[k]}),
                      .op_b({1'b0, m2[k]}), .prod(sq2));

      always_ff @(posedge clock) begin
         if (reset) begin
            s1_vld_ff <= 1'b0;
            s2_vld_ff <= 1'b0;
         end else if (adv) begin
            s1_vld_ff <= vld[k];
            s2_vld_ff <= s1_vld_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s1_side_ff <= side[k];
            s2_side_ff <= s1_side_ff;
         end
      end

      // square overflowing two gives the next fraction bit; renormalize
      assign hi1       = sq1[125:62];
      assign hi2       = sq2[125:62];
      assign m1[k+1]   = hi1[63] ? hi1[63:1] : hi1[62:0];
      assign m2[k+1]   = hi2[63] ? hi2[63:1] : hi2[62:0];
      assign side[k+1] = '{arg: s2_side_ff.arg, e1: s2_side_ff.e1,
                           f1: {s2_side_ff.f1[iefa_pkg::QB-2:0], hi1[63]},
                           f2: {s2_side_ff.f2[iefa_pkg::QB-2:0], hi2[63]}};
      assign vld[k+1]  = s2_vld_ff;
   end

   assign lsum_in = iefa_pkg::LOG_BIAS
                  - 64'({side[iefa_pkg::LOG_STEPS].e1, side[iefa_pkg::LOG_STEPS].f1})
                  - 64'({5'(iefa_pkg::FB), side[iefa_pkg::LOG_STEPS].f2});

   assign out_valid = c_vld_ff;
   assign out_arg   = c_arg_ff;
   assign out_lsum  = c_lsum_ff;

endmodule

[sv/iefa_poly.sv]
// ----------------------------------------------------------------------------
// iefa_poly: back end of the inverse error function block
// Scales by ln2, takes the square root, runs Horner and applies |x|.
// ----------------------------------------------------------------------------
module iefa_poly (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  iefa_pkg::arg_type          in_arg,
   input  logic [63:0]                in_lsum,
   output logic                       out_valid,
   output logic                       out_neg,
   output logic [iefa_pkg::OUT_W-2:0] out_mag
);

   typedef struct packed {
      iefa_pkg::arg_type arg;
      logic              sel;
      logic [63:0]       z;
   } hside_type;

   localparam int RAD_W = 2 * iefa_pkg::SQRT_STEPS;

   // ---------------- w = lsum * ln2 ----------------
   logic [127:0]      w_prod, w_rnd;
   logic              w1_vld_ff, w2_vld_ff, w_vld_ff;
   iefa_pkg::arg_type w1_arg_ff, w2_arg_ff, w_arg_ff;
   logic [63:0]       w_in, w_ff;

   iefa_mul u_wmul (.clock(clock), .adv(adv), .op_a(in_lsum),
                    .op_b(iefa_pkg::LN2_Q), .prod(w_prod));

   assign w_rnd = w_prod + (128'd1 << (iefa_pkg::QB - 1));
   assign w_in  = {1'b0, w_rnd[iefa_pkg::QB+62:iefa_pkg::QB]};

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_vld_ff <= 1'b0;
         w2_vld_ff <= 1'b0;
         w_vld_ff  <= 1'b0;
      end else if (adv) begin
         w1_vld_ff <= in_valid;
         w2_vld_ff <= w1_vld_ff;
         w_vld_ff  <= w2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w1_arg_ff <= in_arg;
         w2_arg_ff <= w1_arg_ff;
         w_arg_ff  <= w2_arg_ff;
         w_ff      <= w_in;
      end
   end

   // ---------------- sqrt(w), one root bit per stage ----------------
   logic [63:0]       rem  [iefa_pkg::SQRT_STEPS+1];
   logic [63:0]       root [iefa_pkg::SQRT_STEPS+1];
   logic [63:0]       sw   [iefa_pkg::SQRT_STEPS+1];
   iefa_pkg::arg_type sarg [iefa_pkg::SQRT_STEPS+1];
   logic              svld [iefa_pkg::SQRT_STEPS+1];

   assign rem[0]  = '0;
   assign root[0] = '0;
   assign sw[0]   = w_ff;
   assign sarg[0] = w_arg_ff;
   assign svld[0] = w_vld_ff;

   for (genvar k = 0; k < iefa_pkg::SQRT_STEPS; k++) begin : g_sqrt
      localparam int PAIR = iefa_pkg::SQRT_STEPS - 1 - k;
      logic [RAD_W-1:0]  rad;
      logic [63:0]       rem_sh, trial, rem_in, root_in, rem_ff, root_ff, w_st_ff;
      logic              ge, vld_ff;
      iefa_pkg::arg_type arg_ff;

      always_comb begin
         rad     = {sw[k][RAD_W-iefa_pkg::QB-1:0], {iefa_pkg::QB{1'b0}}};
         rem_sh  = {rem[k][61:0], rad[2*PAIR+1 -: 2]};
         trial   = {root[k][61:0], 2'b01};
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root[k][62:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= svld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            w_st_ff <= sw[k];
            arg_ff  <= sarg[k];
         end
      end

      assign rem[k+1]  = rem_ff;
      assign root[k+1] = root_ff;
      assign sw[k+1]   = w_st_ff;
      assign sarg[k+1] = arg_ff;
      assign svld[k+1] = vld_ff;
   end

   // ---------------- branch select and polynomial argument ----------------
   logic        sel_in;
   logic [63:0] z_in, p0_in, z_p_ff;
   hside_type   z_side_ff;
   logic        z_vld_ff;

   always_comb begin
      sel_in = (sw[iefa_pkg::SQRT_STEPS] >= iefa_pkg::W_SPLIT);
      z_in   = sel_in ? (root[iefa_pkg::SQRT_STEPS] - iefa_pkg::SQRT_CENTER)
                      : (sw[iefa_pkg::SQRT_STEPS] - iefa_pkg::W_CENTER);
      p0_in  = sel_in ? iefa_pkg::COEF_TAB[iefa_pkg::POLY_BASE] : iefa_pkg::COEF_TAB[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_vld_ff <= 1'b0;
      end else if (adv) begin
         z_vld_ff <= svld[iefa_pkg::SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z_side_ff <= '{arg: sarg[iefa_pkg::SQRT_STEPS], sel: sel_in, z: z_in};
         z_p_ff    <= p0_in;
      end
   end

   // ---------------- Horner steps ----------------
   logic [63:0] hp    [iefa_pkg::HORNER_STEPS+1];
   hside_type   hside [iefa_pkg::HORNER_STEPS+1];
   logic        hvld  [iefa_pkg::HORNER_STEPS+1];

   assign hp[0]    = z_p_ff;
   assign hside[0] = z_side_ff;
   assign hvld[0]  = z_vld_ff;

   for (genvar j = 0; j < iefa_pkg::HORNER_STEPS; j++) begin : g_horner
      logic [63:0]  pa_in, za_in, pa_ff, za_ff, mag_in, mag_ff, coef, p_in, p_ff;
      logic [127:0] prod, rnd;
      logic         sg_in, sg0_ff, sg1_ff, sg2_ff, sg3_ff;
      hside_type    sd0_ff, sd1_ff, sd2_ff, sd3_ff, sd4_ff;
      logic         v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;

      // magnitudes into the multiplier, sign rides alongside
      always_comb begin
         pa_in = hp[j][63] ? (64'd0 - hp[j]) : hp[j];
         za_in = hside[j].z[63] ? (64'd0 - hside[j].z) : hside[j].z;
         sg_in = hp[j][63] ^ hside[j].z[63];
      end

      iefa_mul u_hmul (.clock(clock), .adv(adv), .op_a(pa_ff), .op_b(za_ff), .prod(prod));

      // round half up at 2^-56, keep 63 bits, then add the next coefficient
      always_comb begin
         rnd    = prod + (128'd1 << (iefa_pkg::QB - 1));
         mag_in = {1'b0, rnd[iefa_pkg::QB+62:iefa_pkg::QB]};
         coef   = sd3_ff.sel ? iefa_pkg::COEF_TAB[iefa_pkg::POLY_BASE+1+j]
                             : iefa_pkg::COEF_TAB[1+j];
         p_in   = coef + (sg3_ff ? (64'd0 - mag_ff) : mag_ff);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v0_ff <= 1'b0;
            v1_ff <= 1'b0;
            v2_ff <= 1'b0;
            v3_ff <= 1'b0;
            v4_ff <= 1'b0;
         end else if (adv) begin
            v0_ff <= hvld[j];
            v1_ff <= v0_ff;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pa_ff  <= pa_in;
            za_ff  <= za_in;
            sg0_ff <= sg_in;
            sg1_ff <= sg0_ff;
            sg2_ff <= sg1_ff;
            sg3_ff <= sg2_ff;
            sd0_ff <= hside[j];
            sd1_ff <= sd0_ff;
            sd2_ff <= sd1_ff;
            sd3_ff <= sd2_ff;
            sd4_ff <= sd3_ff;
            mag_ff <= mag_in;
            p_ff   <= p_in;
         end
      end

      assign hp[j+1]    = p_ff;
      assign hside[j+1] = sd4_ff;
      assign hvld[j+1]  = v4_ff;
   end

   // ---------------- scale by |x|, round and saturate ----------------
   logic [63:0]                 pc;
   logic [127:0]                f_prod, f_rnd;
   logic [127-iefa_pkg::FINAL_SHIFT:0] f_q;
   logic                        f1_vld_ff, f2_vld_ff, f3_vld_ff;
   iefa_pkg::arg_type           f1_arg_ff, f2_arg_ff;
   logic                        f3_neg_ff;
   logic [iefa_pkg::OUT_W-2:0]  f_mag_in, f3_mag_ff;

   assign pc = hp[iefa_pkg::HORNER_STEPS][63] ? '0 : hp[iefa_pkg::HORNER_STEPS];

   iefa_mul u_fmul (.clock(clock), .adv(adv), .op_a(pc),
                    .op_b(64'(hside[iefa_pkg::HORNER_STEPS].arg.mag)), .prod(f_prod));

   always_comb begin
      f_rnd    = f_prod + (128'd1 << (iefa_pkg::FINAL_SHIFT - 1));
      f_q      = f_rnd[127:iefa_pkg::FINAL_SHIFT];
      f_mag_in = (|f_q[127-iefa_pkg::FINAL_SHIFT:iefa_pkg::OUT_W-1]) ? '1
                                                   : f_q[iefa_pkg::OUT_W-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
         f3_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= hvld[iefa_pkg::HORNER_STEPS];
         f2_vld_ff <= f1_vld_ff;
         f3_vld_ff <= f2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_arg_ff <= hside[iefa_pkg::HORNER_STEPS].arg;
         f2_arg_ff <= f1_arg_ff;
         f3_neg_ff <= f2_arg_ff.neg;
         f3_mag_ff <= f_mag_in;
      end
   end

   assign out_valid = f3_vld_ff;
   assign out_neg   = f3_neg_ff;
   assign out_mag   = f3_mag_ff;

endmodule

[sv/inverse_error_function_approx_top.sv]
// ----------------------------------------------------------------------------
// inverse_error_function_approx_top: fixed-point erfinv, Q1.31 in, Q5.27 out
// Front queue, log pipeline, polynomial pipeline and output register.
// ----------------------------------------------------------------------------
// The block takes one argument per cycle while req_ready is high and returns
// erfinv of it, one result per transfer, in order. The 56 squaring steps of
// the logarithm (two stages each), the 59-stage square root and the eight
// five-stage Horner steps all share one advance signal. The pipeline moves
// whenever the output register is empty or being taken; while the output is
// stalled, a four-entry queue keeps accepting arguments, and req_ready drops
// only when that queue is full. The most negative input is treated as
// -(1 - 2^-31) so it gives a finite result; results beyond the Q5.27 range
// saturate to +-(2^31 - 1).
// ----------------------------------------------------------------------------
module inverse_error_function_approx_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [iefa_pkg::IN_W-1:0]  req_x_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [iefa_pkg::OUT_W-1:0] rsp_inverse_value
);

   logic                       adv;
   logic                       head_valid, pop;
   iefa_pkg::arg_type          head_arg;
   logic                       log_valid;
   iefa_pkg::arg_type          log_arg;
   logic [63:0]                log_lsum;
   logic                       poly_valid, poly_neg;
   logic [iefa_pkg::OUT_W-2:0] poly_mag;
   logic                       rsp_valid_ff;
   logic [iefa_pkg::OUT_W-1:0] rsp_value_ff, rsp_value_in;

   // advance the whole back end unless a finished result is still waiting
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && head_valid;

   iefa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_value (req_x_value),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_arg    (head_arg)
   );

   iefa_log u_log (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (head_valid),
      .in_arg    (head_arg),
      .out_valid (log_valid),
      .out_arg   (log_arg),
      .out_lsum  (log_lsum)
   );

   iefa_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (log_valid),
      .in_arg    (log_arg),
      .in_lsum   (log_lsum),
      .out_valid (poly_valid),
      .out_neg   (poly_neg),
      .out_mag   (poly_mag)
   );

   // apply the argument's sign to the saturated magnitude
   assign rsp_value_in = poly_neg ? (~{1'b0, poly_mag} + 1'b1) : {1'b0, poly_mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= poly_valid;
      end
   end

   // hold the result until its transfer completes
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_inverse_value = rsp_value_ff;

endmodule
